// ===== hdl/uct_pkg.sv =====
// Package for the case traits block: family codes, result type and classify function.
package uct_pkg;

   localparam int CpWidth = 16;

   typedef enum logic [1:0] {
      FAM_NONE  = 2'd0,
      FAM_LATIN = 2'd1,
      FAM_GREEK = 2'd2,
      FAM_CYR   = 2'd3
   } family_type;

   typedef struct packed {
      family_type           fam;
      logic                 up;
      logic [CpWidth-1:0]   oc;
   } traits_type;

   function automatic traits_type mk(family_type f, logic u, logic [15:0] o);
      traits_type t;
      t.fam = f;
      t.up  = u;
      t.oc  = o;
      return t;
   endfunction

   function automatic traits_type pair(family_type f, logic [15:0] c, logic upper_even);
      traits_type t;
      if ((~c[0]) == upper_even) begin
         t = mk(f, 1'b1, c + 16'd1);
      end else begin
         t = mk(f, 1'b0, c - 16'd1);
      end
      return t;
   endfunction

   function automatic traits_type latin_low(logic [15:0] c);
      traits_type t;
      if (c >= 16'h41 && c <= 16'h5A) t = mk(FAM_LATIN, 1'b1, c + 16'h20);
      else if (c >= 16'h61 && c <= 16'h7A) t = mk(FAM_LATIN, 1'b0, c - 16'h20);
      else if (c >= 16'hC0 && c <= 16'hDE) begin
         if (c != 16'hD7) t = mk(FAM_LATIN, 1'b1, c + 16'h20);
         else t = mk(FAM_NONE, 1'b0, c);
      end else if (c >= 16'hDF) begin
         if (c == 16'hDF) t = mk(FAM_LATIN, 1'b0, c);
         else if (c == 16'hFF) t = mk(FAM_LATIN, 1'b0, 16'h0178);
         else if (c != 16'hF7) t = mk(FAM_LATIN, 1'b0, c - 16'h20);
         else t = mk(FAM_NONE, 1'b0, c);
      end else if (c == 16'h40 || (c >= 16'h24 && c <= 16'h26)) t = mk(FAM_LATIN, 1'b0, c);
      else if ((c >= 16'hA2 && c <= 16'hA5) || c == 16'hA9 || c == 16'hAE || c == 16'hB5)
         t = mk(FAM_LATIN, 1'b0, c);
      else t = mk(FAM_NONE, 1'b0, c);
      return t;
   endfunction

   function automatic traits_type latin_b_mid(logic [15:0] c);
      traits_type t;
      case (c)
         16'h182, 16'h184, 16'h187, 16'h18B, 16'h191, 16'h198, 16'h1A0, 16'h1A2,
         16'h1A4, 16'h1A7, 16'h1AC, 16'h1AF, 16'h1B3, 16'h1B5, 16'h1BC:
            t = mk(FAM_LATIN, 1'b1, c + 16'd1);
         16'h183, 16'h185, 16'h188, 16'h18C, 16'h192, 16'h199, 16'h1A1, 16'h1A3,
         16'h1A5, 16'h1A8, 16'h1AD, 16'h1B0, 16'h1B4, 16'h1B6, 16'h1BD:
            t = mk(FAM_LATIN, 1'b0, c - 16'd1);
         16'h180, 16'h18D, 16'h195, 16'h19A, 16'h19B, 16'h19E, 16'h1AB, 16'h1BA,
         16'h1BE:
            t = mk(FAM_LATIN, 1'b0, c);
         16'h18E: t = mk(FAM_LATIN, 1'b1, 16'h01DD);
         default: t = mk(FAM_LATIN, 1'b1, c);
      endcase
      return t;
   endfunction

   function automatic traits_type latin_ext(logic [15:0] c);
      traits_type t;
      if (c <= 16'h17F) begin
         if (c <= 16'h177 && (c <= 16'h137 || c >= 16'h14A)) t = pair(FAM_LATIN, c, 1'b1);
         else if (c >= 16'h179 || (c >= 16'h139 && c <= 16'h148))
            t = pair(FAM_LATIN, c, 1'b0);
         else if (c == 16'h178) t = mk(FAM_LATIN, 1'b1, 16'h00FF);
         else t = mk(FAM_LATIN, 1'b0, c);
      end else if (c >= 16'h1CD && c <= 16'h233) begin
         if (c <= 16'h1DC) t = pair(FAM_LATIN, c, 1'b0);
         else if (c <= 16'h1EF || c >= 16'h1F4) begin
            if (c == 16'h1DD) t = mk(FAM_LATIN, 1'b0, 16'h018E);
            else t = pair(FAM_LATIN, c, 1'b1);
         end else if (c == 16'h1F0) t = mk(FAM_LATIN, 1'b0, c);
         else if (c == 16'h1F3) t = mk(FAM_LATIN, 1'b0, 16'h01F1);
         else t = mk(FAM_LATIN, 1'b1, 16'h01F3);
      end else if (c >= 16'h246) t = pair(FAM_LATIN, c, 1'b1);
      else if (c <= 16'h1BF) t = latin_b_mid(c);
      else if (c >= 16'h1C4 && c <= 16'h1CC) begin
         if (c == 16'h1C4 || c == 16'h1C7 || c == 16'h1CA) t = mk(FAM_LATIN, 1'b1, c + 16'd2);
         else if (c == 16'h1C5 || c == 16'h1C8 || c == 16'h1CB)
            t = mk(FAM_LATIN, 1'b1, c + 16'd1);
         else t = mk(FAM_LATIN, 1'b1, c - 16'd2);
      end else if (c >= 16'h23A) begin
         case (c)
            16'h23B: t = mk(FAM_LATIN, 1'b1, 16'h023C);
            16'h23C: t = mk(FAM_LATIN, 1'b0, 16'h023B);
            16'h241: t = mk(FAM_LATIN, 1'b1, 16'h0242);
            16'h242: t = mk(FAM_LATIN, 1'b0, 16'h0241);
            16'h23F, 16'h240: t = mk(FAM_LATIN, 1'b0, c);
            default: t = mk(FAM_LATIN, 1'b1, c);
         endcase
      end else if (c >= 16'h234) t = mk(FAM_LATIN, 1'b0, c);
      else t = mk(FAM_NONE, 1'b0, c);
      return t;
   endfunction

   function automatic traits_type greek_basic(logic [15:0] c);
      traits_type t;
      if (c >= 16'h391 && c <= 16'h3AB) t = mk(FAM_GREEK, 1'b1, c + 16'h20);
      else if (c >= 16'h3B1 && c <= 16'h3CB) t = mk(FAM_GREEK, 1'b0, c - 16'h20);
      else if (c >= 16'h3AC && c <= 16'h3B0) begin
         case (c)
            16'h3AC: t = mk(FAM_GREEK, 1'b0, 16'h0386);
            16'h3AD: t = mk(FAM_GREEK, 1'b0, 16'h0388);
            16'h3AE: t = mk(FAM_GREEK, 1'b0, 16'h0389);
            16'h3AF: t = mk(FAM_GREEK, 1'b0, 16'h038A);
            default: t = mk(FAM_GREEK, 1'b0, c);
         endcase
      end else if (c < 16'h370) t = mk(FAM_NONE, 1'b0, c);
      else if (c <= 16'h377) begin
         if (c == 16'h374 || c == 16'h375) t = mk(FAM_NONE, 1'b0, c);
         else t = pair(FAM_GREEK, c, 1'b1);
      end else if (c >= 16'h3CC) begin
         if (c >= 16'h3D8 && c <= 16'h3EF) t = pair(FAM_GREEK, c, 1'b1);
         else if (c >= 16'h3FD) t = mk(FAM_GREEK, 1'b1, c - 16'h82);
         else begin
            case (c)
               16'h3CC: t = mk(FAM_GREEK, 1'b0, 16'h038C);
               16'h3CD: t = mk(FAM_GREEK, 1'b0, 16'h038E);
               16'h3CE: t = mk(FAM_GREEK, 1'b0, 16'h038F);
               16'h3CF: t = mk(FAM_GREEK, 1'b1, 16'h03D7);
               16'h3D1: t = mk(FAM_GREEK, 1'b0, 16'h03F4);
               16'h3D7: t = mk(FAM_GREEK, 1'b1, 16'h03CF);
               16'h3F2: t = mk(FAM_GREEK, 1'b0, 16'h03F9);
               16'h3F3: t = mk(FAM_GREEK, 1'b0, 16'h037F);
               16'h3F4: t = mk(FAM_GREEK, 1'b1, 16'h03D1);
               16'h3F7: t = mk(FAM_GREEK, 1'b1, 16'h03F8);
               16'h3F8: t = mk(FAM_GREEK, 1'b0, 16'h03F7);
               16'h3F9: t = mk(FAM_GREEK, 1'b1, 16'h03F2);
               16'h3FA: t = mk(FAM_GREEK, 1'b1, 16'h03FB);
               16'h3FB: t = mk(FAM_GREEK, 1'b0, 16'h03FA);
               default: t = mk(FAM_GREEK, 1'b0, c);
            endcase
         end
      end else if (c >= 16'h37B && c <= 16'h37D) t = mk(FAM_GREEK, 1'b0, c + 16'h82);
      else begin
         case (c)
            16'h37F: t = mk(FAM_GREEK, 1'b1, 16'h03F3);
            16'h386: t = mk(FAM_GREEK, 1'b1, 16'h03AC);
            16'h388: t = mk(FAM_GREEK, 1'b1, 16'h03AD);
            16'h389: t = mk(FAM_GREEK, 1'b1, 16'h03AE);
            16'h38A: t = mk(FAM_GREEK, 1'b1, 16'h03AF);
            16'h38C: t = mk(FAM_GREEK, 1'b1, 16'h03CC);
            16'h38E: t = mk(FAM_GREEK, 1'b1, 16'h03CD);
            16'h38F: t = mk(FAM_GREEK, 1'b1, 16'h03CE);
            16'h390: t = mk(FAM_GREEK, 1'b0, c);
            default: t = mk(FAM_NONE, 1'b0, c);
         endcase
      end
      return t;
   endfunction

   // Upper partner of 0x1F70..0x1F7D, indexed by low nibble.
   function automatic logic [15:0] vowel_up(logic [3:0] r);
      logic [15:0] v;
      case (r)
         4'h0: v = 16'h1FBA;
         4'h1: v = 16'h1FBB;
         4'h2: v = 16'h1FC8;
         4'h3: v = 16'h1FC9;
         4'h4: v = 16'h1FCA;
         4'h5: v = 16'h1FCB;
         4'h6: v = 16'h1FDA;
         4'h7: v = 16'h1FDB;
         4'h8: v = 16'h1FF8;
         4'h9: v = 16'h1FF9;
         4'hA: v = 16'h1FEA;
         4'hB: v = 16'h1FEB;
         4'hC: v = 16'h1FFA;
         default: v = 16'h1FFB;
      endcase
      return v;
   endfunction

   function automatic traits_type greek_ext(logic [15:0] c);
      traits_type t;
      logic [3:0] row;
      row = c[3:0];
      if (c <= 16'h1FAF) begin
         if (c[15:4] != 12'h1F7) begin
            if (row <= 4'd7) begin
               if (c == 16'h1F16 || c == 16'h1F17 || c == 16'h1F46 || c == 16'h1F47)
                  t = mk(FAM_NONE, 1'b0, c);
               else t = mk(FAM_GREEK, 1'b0, c + 16'd8);
            end else if (c == 16'h1F1E || c == 16'h1F1F || c == 16'h1F4E || c == 16'h1F4F)
               t = mk(FAM_NONE, 1'b0, c);
            else t = mk(FAM_GREEK, 1'b1, c - 16'd8);
         end else if (row <= 4'hD) t = mk(FAM_GREEK, 1'b0, vowel_up(row));
         else t = mk(FAM_NONE, 1'b0, c);
      end else begin
         case (c)
            16'h1FB0: t = mk(FAM_GREEK, 1'b0, 16'h1FB8);
            16'h1FB1: t = mk(FAM_GREEK, 1'b0, 16'h1FB9);
            16'h1FB3: t = mk(FAM_GREEK, 1'b0, 16'h1FBC);
            16'h1FD0: t = mk(FAM_GREEK, 1'b0, 16'h1FD8);
            16'h1FD1: t = mk(FAM_GREEK, 1'b0, 16'h1FD9);
            16'h1FE0: t = mk(FAM_GREEK, 1'b0, 16'h1FE8);
            16'h1FE1: t = mk(FAM_GREEK, 1'b0, 16'h1FE9);
            16'h1FF3: t = mk(FAM_GREEK, 1'b0, 16'h1FFC);
            16'h1FE5: t = mk(FAM_GREEK, 1'b0, 16'h1FEC);
            16'h1FB8: t = mk(FAM_GREEK, 1'b1, 16'h1FB0);
            16'h1FB9: t = mk(FAM_GREEK, 1'b1, 16'h1FB1);
            16'h1FBC: t = mk(FAM_GREEK, 1'b1, 16'h1FB3);
            16'h1FD8: t = mk(FAM_GREEK, 1'b1, 16'h1FD0);
            16'h1FD9: t = mk(FAM_GREEK, 1'b1, 16'h1FD1);
            16'h1FE8: t = mk(FAM_GREEK, 1'b1, 16'h1FE0);
            16'h1FE9: t = mk(FAM_GREEK, 1'b1, 16'h1FE1);
            16'h1FFC: t = mk(FAM_GREEK, 1'b1, 16'h1FF3);
            16'h1FEC: t = mk(FAM_GREEK, 1'b1, 16'h1FE5);
            16'h1FBA: t = mk(FAM_GREEK, 1'b1, 16'h1F70);
            16'h1FBB: t = mk(FAM_GREEK, 1'b1, 16'h1F71);
            16'h1FC8: t = mk(FAM_GREEK, 1'b1, 16'h1F72);
            16'h1FC9: t = mk(FAM_GREEK, 1'b1, 16'h1F73);
            16'h1FCA: t = mk(FAM_GREEK, 1'b1, 16'h1F74);
            16'h1FCB: t = mk(FAM_GREEK, 1'b1, 16'h1F75);
            16'h1FDA: t = mk(FAM_GREEK, 1'b1, 16'h1F76);
            16'h1FDB: t = mk(FAM_GREEK, 1'b1, 16'h1F77);
            16'h1FF8: t = mk(FAM_GREEK, 1'b1, 16'h1F78);
            16'h1FF9: t = mk(FAM_GREEK, 1'b1, 16'h1F79);
            16'h1FEA: t = mk(FAM_GREEK, 1'b1, 16'h1F7A);
            16'h1FEB: t = mk(FAM_GREEK, 1'b1, 16'h1F7B);
            16'h1FFA: t = mk(FAM_GREEK, 1'b1, 16'h1F7C);
            16'h1FFB: t = mk(FAM_GREEK, 1'b1, 16'h1F7D);
            default: begin
               if (row >= 4'd2 && row <= 4'hB && row != 4'd5 && c != 16'h1FD4)
                  t = mk(FAM_GREEK, row > 4'd7, c);
               else t = mk(FAM_NONE, 1'b0, c);
            end
         endcase
      end
      return t;
   endfunction

   function automatic traits_type classify(logic [15:0] c);
      traits_type t;
      if (c <= 16'hFF) t = latin_low(c);
      else if (c <= 16'h24F) t = latin_ext(c);
      else if (c <= 16'h3FF) t = greek_basic(c);
      else if (c <= 16'h520) t = mk(FAM_CYR, 1'b0, c);
      else if (c >= 16'h1C80 && c <= 16'h1C8F) t = mk(FAM_CYR, 1'b0, c);
      else if (c >= 16'h1E00 && c <= 16'h1EFF) begin
         if (c <= 16'h1E95 || c >= 16'h1EA0) t = pair(FAM_LATIN, c, 1'b1);
         else t = mk(FAM_LATIN, 1'b0, c);
      end else if (c >= 16'h1F00 && c <= 16'h1FFF) t = greek_ext(c);
      else if (c >= 16'h2DE0 && c <= 16'h2DFF) t = mk(FAM_CYR, 1'b0, c);
      else if (c >= 16'hA640 && c <= 16'hA69F) t = mk(FAM_CYR, 1'b0, c);
      else t = mk(FAM_NONE, 1'b0, c);
      return t;
   endfunction

endpackage

// ===== hdl/uct_if.sv =====
// Handshake channel interfaces for requests and responses.
interface uct_req_if (input logic clock);
   logic                        valid;
   logic                        ready;
   logic [uct_pkg::CpWidth-1:0] code_point;
   modport source (output valid, output code_point, input ready);
   modport sink (input valid, input code_point, output ready);
endinterface

interface uct_rsp_if (input logic clock);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  script_family;
   logic                        is_upper;
   logic [uct_pkg::CpWidth-1:0] other_case;
   modport source (output valid, output script_family, output is_upper, output other_case,
                   input ready);
   modport sink (input valid, input script_family, input is_upper, input other_case,
                 output ready);
endinterface

// ===== hdl/unicode_case_traits_core.sv =====
// Top level: per-character Unicode case traits, input register then result register.
//
//  channel  dir  payload
//  req_     in   code_point[15:0]
//  rsp_     out  script_family[1:0], is_upper, other_case[15:0]
//
// A request passes through the input register and then the result register to the response;
// one request per cycle sustained while rsp_ch.ready holds. Input register stage, classify logic,
// result register stage; each stage advances when empty or when the stage after it moves.
// Reset (synchronous) clears both stage valid flags.
module unicode_case_traits_core (
   input logic          clock,
   input logic          reset,
   uct_req_if.sink      req_ch,
   uct_rsp_if.source    rsp_ch
);

   logic                        in_valid_ff, in_valid_in;
   logic [uct_pkg::CpWidth-1:0] in_cp_ff;
   logic                        out_valid_ff, out_valid_in;
   uct_pkg::traits_type         out_ff, traits;
   logic                        out_adv, in_adv;

   assign traits  = uct_pkg::classify(in_cp_ff);
   assign out_adv = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign in_adv  = !in_valid_ff || out_adv;
   assign req_ch.ready = in_adv;

   always_comb begin
      in_valid_in  = req_ch.valid || (in_valid_ff && !out_adv);
      out_valid_in = out_adv || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_adv) in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_adv && req_ch.valid) in_cp_ff <= req_ch.code_point;
      if (out_adv) out_ff <= traits;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.script_family = out_ff.fam;
   assign rsp_ch.is_upper      = out_ff.up;
   assign rsp_ch.other_case    = out_ff.oc;

endmodule

// ===== tb/tb_unicode_case_traits_core.sv =====
// Testbench for the Unicode case traits core: directed table, then random code points.
`timescale 1ns / 100ps

module tb_unicode_case_traits_core;

   typedef struct {
      logic [15:0]         cp;
      logic                known;
      uct_pkg::family_type fam;
      logic                up;
      logic [15:0]         oc;
   } vector_type;

   typedef struct {
      uct_pkg::family_type fam;
      logic                up;
      logic [15:0]         oc;
   } case_traits_type;

   localparam int RandomCount = 1100;
   localparam int StallLimit  = 2000;
   localparam int DirectedCount = 25;

   logic clock;
   logic reset;

   uct_req_if req_ch (clock);
   uct_rsp_if rsp_ch (clock);

   unicode_case_traits_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   case_traits_type expected_traits[$];
   vector_type      directed[DirectedCount];
   int              error_count;
   int              idle_count;
   bit              send_done;
   bit              calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Case pairs of the 0x1F70 vowel row and the 0x1FB0 tail area.
   function automatic logic [15:0] vowel_upper(logic [3:0] r);
      logic [15:0] tbl[14];
      tbl = '{16'h1FBA, 16'h1FBB, 16'h1FC8, 16'h1FC9, 16'h1FCA, 16'h1FCB, 16'h1FDA,
              16'h1FDB, 16'h1FF8, 16'h1FF9, 16'h1FEA, 16'h1FEB, 16'h1FFA, 16'h1FFB};
      return tbl[r];
   endfunction

   function automatic case_traits_type traits(uct_pkg::family_type f, logic u,
                                              logic [15:0] o);
      case_traits_type t;
      t.fam = f;
      t.up  = u;
      t.oc  = o;
      return t;
   endfunction

   function automatic case_traits_type paired(uct_pkg::family_type f, logic [15:0] c,
                                              bit up_even);
      if ((c[0] == 1'b0) == up_even) return traits(f, 1'b1, c + 16'd1);
      return traits(f, 1'b0, c - 16'd1);
   endfunction

   function automatic case_traits_type predict_latin(logic [15:0] c);
      if (c <= 16'hFF) begin
         if (c >= 16'h41 && c <= 16'h5A) return traits(uct_pkg::FAM_LATIN, 1'b1, c + 16'h20);
         if (c >= 16'h61 && c <= 16'h7A) return traits(uct_pkg::FAM_LATIN, 1'b0, c - 16'h20);
         if (c == 16'hD7 || c == 16'hF7) return traits(uct_pkg::FAM_NONE, 1'b0, c);
         if (c >= 16'hC0 && c <= 16'hDE) return traits(uct_pkg::FAM_LATIN, 1'b1, c + 16'h20);
         if (c == 16'hDF) return traits(uct_pkg::FAM_LATIN, 1'b0, c);
         if (c == 16'hFF) return traits(uct_pkg::FAM_LATIN, 1'b0, 16'h0178);
         if (c > 16'hDF) return traits(uct_pkg::FAM_LATIN, 1'b0, c - 16'h20);
         if (c == 16'h40 || (c >= 16'h24 && c <= 16'h26) || (c >= 16'hA2 && c <= 16'hA5)
             || c == 16'hA9 || c == 16'hAE || c == 16'hB5)
            return traits(uct_pkg::FAM_LATIN, 1'b0, c);
         return traits(uct_pkg::FAM_NONE, 1'b0, c);
      end
      if (c <= 16'h17F) begin
         if (c == 16'h178) return traits(uct_pkg::FAM_LATIN, 1'b1, 16'h00FF);
         if (c <= 16'h137 || (c >= 16'h14A && c <= 16'h177))
            return paired(uct_pkg::FAM_LATIN, c, 1'b1);
         if (c >= 16'h179 || (c >= 16'h139 && c <= 16'h148))
            return paired(uct_pkg::FAM_LATIN, c, 1'b0);
         return traits(uct_pkg::FAM_LATIN, 1'b0, c);
      end
      if (c >= 16'h1CD && c <= 16'h233) begin
         if (c <= 16'h1DC) return paired(uct_pkg::FAM_LATIN, c, 1'b0);
         if (c == 16'h1DD) return traits(uct_pkg::FAM_LATIN, 1'b0, 16'h018E);
         if (c <= 16'h1EF || c >= 16'h1F4) return paired(uct_pkg::FAM_LATIN, c, 1'b1);
         if (c == 16'h1F0) return traits(uct_pkg::FAM_LATIN, 1'b0, c);
         if (c == 16'h1F3) return traits(uct_pkg::FAM_LATIN, 1'b0, 16'h01F1);
         return traits(uct_pkg::FAM_LATIN, 1'b1, 16'h01F3);
      end
      if (c >= 16'h246) return paired(uct_pkg::FAM_LATIN, c, 1'b1);
      if (c <= 16'h1BF) begin
         case (c)
            16'h182, 16'h184, 16'h187, 16'h18B, 16'h191, 16'h198, 16'h1A0, 16'h1A2,
            16'h1A4, 16'h1A7, 16'h1AC, 16'h1AF, 16'h1B3, 16'h1B5, 16'h1BC:
               return traits(uct_pkg::FAM_LATIN, 1'b1, c + 16'd1);
            16'h183, 16'h185, 16'h188, 16'h18C, 16'h192, 16'h199, 16'h1A1, 16'h1A3,
            16'h1A5, 16'h1A8, 16'h1AD, 16'h1B0, 16'h1B4, 16'h1B6, 16'h1BD:
               return traits(uct_pkg::FAM_LATIN, 1'b0, c - 16'd1);
            16'h180, 16'h18D, 16'h195, 16'h19A, 16'h19B, 16'h19E, 16'h1AB, 16'h1BA,
            16'h1BE:
               return traits(uct_pkg::FAM_LATIN, 1'b0, c);
            16'h18E: return traits(uct_pkg::FAM_LATIN, 1'b1, 16'h01DD);
            default: return traits(uct_pkg::FAM_LATIN, 1'b1, c);
         endcase
      end
      if (c >= 16'h1C4 && c <= 16'h1CC) begin
         if (c == 16'h1C4 || c == 16'h1C7 || c == 16'h1CA)
            return traits(uct_pkg::FAM_LATIN, 1'b1, c + 16'd2);
         if (c == 16'h1C5 || c == 16'h1C8 || c == 16'h1CB)
            return traits(uct_pkg::FAM_LATIN, 1'b1, c + 16'd1);
         return traits(uct_pkg::FAM_LATIN, 1'b1, c - 16'd2);
      end
      if (c >= 16'h23A) begin
         case (c)
            16'h23B: return traits(uct_pkg::FAM_LATIN, 1'b1, 16'h023C);
            16'h23C: return traits(uct_pkg::FAM_LATIN, 1'b0, 16'h023B);
            16'h241: return traits(uct_pkg::FAM_LATIN, 1'b1, 16'h0242);
            16'h242: return traits(uct_pkg::FAM_LATIN, 1'b0, 16'h0241);
            16'h23F, 16'h240: return traits(uct_pkg::FAM_LATIN, 1'b0, c);
            default: return traits(uct_pkg::FAM_LATIN, 1'b1, c);
         endcase
      end
      if (c >= 16'h234) return traits(uct_pkg::FAM_LATIN, 1'b0, c);
      return traits(uct_pkg::FAM_NONE, 1'b0, c);
   endfunction

   function automatic case_traits_type predict_greek(logic [15:0] c);
      logic [3:0] r;
      r = c[3:0];
      if (c < 16'h1000) begin
         if (c >= 16'h391 && c <= 16'h3AB) return traits(uct_pkg::FAM_GREEK, 1'b1, c + 16'h20);
         if (c >= 16'h3B1 && c <= 16'h3CB) return traits(uct_pkg::FAM_GREEK, 1'b0, c - 16'h20);
         if (c >= 16'h3D8 && c <= 16'h3EF) return paired(uct_pkg::FAM_GREEK, c, 1'b1);
         if (c >= 16'h3FD) return traits(uct_pkg::FAM_GREEK, 1'b1, c - 16'h82);
         if (c >= 16'h37B && c <= 16'h37D) return traits(uct_pkg::FAM_GREEK, 1'b0, c + 16'h82);
         if (c < 16'h370 || c == 16'h374 || c == 16'h375)
            return traits(uct_pkg::FAM_NONE, 1'b0, c);
         if (c <= 16'h377) return paired(uct_pkg::FAM_GREEK, c, 1'b1);
         case (c)
            16'h3AC: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h0386);
            16'h3AD: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h0388);
            16'h3AE: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h0389);
            16'h3AF: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h038A);
            16'h3CC: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h038C);
            16'h3CD: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h038E);
            16'h3CE: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h038F);
            16'h3CF: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03D7);
            16'h3D1: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h03F4);
            16'h3D7: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03CF);
            16'h3F2: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h03F9);
            16'h3F3: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h037F);
            16'h3F4: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03D1);
            16'h3F7: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03F8);
            16'h3F8: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h03F7);
            16'h3F9: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03F2);
            16'h3FA: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03FB);
            16'h3FB: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h03FA);
            16'h37F: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03F3);
            16'h386: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03AC);
            16'h388: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03AD);
            16'h389: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03AE);
            16'h38A: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03AF);
            16'h38C: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03CC);
            16'h38E: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03CD);
            16'h38F: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h03CE);
            default: begin
               if (c >= 16'h3CC || c == 16'h390 || c == 16'h3B0)
                  return traits(uct_pkg::FAM_GREEK, 1'b0, c);
               return traits(uct_pkg::FAM_NONE, 1'b0, c);
            end
         endcase
      end
      if (c <= 16'h1FAF) begin
         if (c[15:4] == 12'h1F7) begin
            if (r <= 4'hD) return traits(uct_pkg::FAM_GREEK, 1'b0, vowel_upper(r));
            return traits(uct_pkg::FAM_NONE, 1'b0, c);
         end
         if (c == 16'h1F16 || c == 16'h1F17 || c == 16'h1F46 || c == 16'h1F47 ||
             c == 16'h1F1E || c == 16'h1F1F || c == 16'h1F4E || c == 16'h1F4F)
            return traits(uct_pkg::FAM_NONE, 1'b0, c);
         if (r <= 4'd7) return traits(uct_pkg::FAM_GREEK, 1'b0, c + 16'd8);
         return traits(uct_pkg::FAM_GREEK, 1'b1, c - 16'd8);
      end
      case (c)
         16'h1FB0: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FB8);
         16'h1FB1: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FB9);
         16'h1FB3: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FBC);
         16'h1FD0: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FD8);
         16'h1FD1: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FD9);
         16'h1FE0: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FE8);
         16'h1FE1: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FE9);
         16'h1FF3: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FFC);
         16'h1FE5: return traits(uct_pkg::FAM_GREEK, 1'b0, 16'h1FEC);
         16'h1FB8: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FB0);
         16'h1FB9: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FB1);
         16'h1FBC: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FB3);
         16'h1FD8: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FD0);
         16'h1FD9: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FD1);
         16'h1FE8: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FE0);
         16'h1FE9: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FE1);
         16'h1FFC: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FF3);
         16'h1FEC: return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1FE5);
         default: ;
      endcase
      for (int i = 0; i < 14; i++) begin
         if (c == vowel_upper(i[3:0]))
            return traits(uct_pkg::FAM_GREEK, 1'b1, 16'h1F70 + 16'(i));
      end
      if (r >= 4'd2 && r <= 4'hB && r != 4'd5 && c != 16'h1FD4)
         return traits(uct_pkg::FAM_GREEK, r > 4'd7, c);
      return traits(uct_pkg::FAM_NONE, 1'b0, c);
   endfunction

   function automatic case_traits_type predict_case_traits(logic [15:0] c);
      if (c <= 16'h24F) return predict_latin(c);
      if (c <= 16'h3FF || (c >= 16'h1F00 && c <= 16'h1FFF)) return predict_greek(c);
      if (c <= 16'h520 || (c >= 16'h1C80 && c <= 16'h1C8F) ||
          (c >= 16'h2DE0 && c <= 16'h2DFF) || (c >= 16'hA640 && c <= 16'hA69F))
         return traits(uct_pkg::FAM_CYR, 1'b0, c);
      if (c >= 16'h1E00 && c <= 16'h1EFF) begin
         if (c <= 16'h1E95 || c >= 16'h1EA0) return paired(uct_pkg::FAM_LATIN, c, 1'b1);
         return traits(uct_pkg::FAM_LATIN, 1'b0, c);
      end
      return traits(uct_pkg::FAM_NONE, 1'b0, c);
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // Rows with known=1 carry a hand-written expectation that must agree with the predictor.
   initial begin
      directed = '{
         '{16'h0000, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'h0000},
         '{16'hFFFF, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'hFFFF},
         '{16'h0041, 1'b1, uct_pkg::FAM_LATIN, 1'b1, 16'h0061},
         '{16'h007A, 1'b1, uct_pkg::FAM_LATIN, 1'b0, 16'h005A},
         '{16'h0024, 1'b1, uct_pkg::FAM_LATIN, 1'b0, 16'h0024},
         '{16'h00B5, 1'b1, uct_pkg::FAM_LATIN, 1'b0, 16'h00B5},
         '{16'h00D7, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'h00D7},
         '{16'h00FF, 1'b1, uct_pkg::FAM_LATIN, 1'b0, 16'h0178},
         '{16'h0178, 1'b1, uct_pkg::FAM_LATIN, 1'b1, 16'h00FF},
         '{16'h018E, 1'b1, uct_pkg::FAM_LATIN, 1'b1, 16'h01DD},
         '{16'h01DD, 1'b1, uct_pkg::FAM_LATIN, 1'b0, 16'h018E},
         '{16'h01F3, 1'b1, uct_pkg::FAM_LATIN, 1'b0, 16'h01F1},
         '{16'h01C0, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'h01C0},
         '{16'h0374, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'h0374},
         '{16'h0391, 1'b1, uct_pkg::FAM_GREEK, 1'b1, 16'h03B1},
         '{16'h03FF, 1'b1, uct_pkg::FAM_GREEK, 1'b1, 16'h037D},
         '{16'h0400, 1'b1, uct_pkg::FAM_CYR,   1'b0, 16'h0400},
         '{16'hA69F, 1'b1, uct_pkg::FAM_CYR,   1'b0, 16'hA69F},
         '{16'h1FD4, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'h1FD4},
         '{16'h1F16, 1'b1, uct_pkg::FAM_NONE,  1'b0, 16'h1F16},
         '{16'h1F7D, 1'b1, uct_pkg::FAM_GREEK, 1'b0, 16'h1FFB},
         '{16'h1E96, 1'b0, uct_pkg::FAM_NONE,  1'b0, 16'h0000},
         '{16'h1FB3, 1'b0, uct_pkg::FAM_NONE,  1'b0, 16'h0000},
         '{16'h01C5, 1'b0, uct_pkg::FAM_NONE,  1'b0, 16'h0000},
         '{16'h023B, 1'b0, uct_pkg::FAM_NONE,  1'b0, 16'h0000}
      };
   end

   function automatic logic [15:0] random_code_point();
      case ($urandom_range(0, 9))
         0: return 16'($urandom_range(16'h0000, 16'h00FF));
         1, 2: return 16'($urandom_range(16'h0100, 16'h024F));
         3, 4: return 16'($urandom_range(16'h0370, 16'h03FF));
         5: return 16'($urandom_range(16'h1E00, 16'h1EFF));
         6, 7: return 16'($urandom_range(16'h1F00, 16'h1FFF));
         8: return 16'($urandom_range(16'h0400, 16'h0530));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(logic [15:0] cp);
      req_ch.valid      <= 1'b1;
      req_ch.code_point <= cp;
      do @(posedge clock); while (!req_ch.ready);
      expected_traits.push_back(predict_case_traits(cp));
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   initial begin
      case_traits_type t;
      error_count       = 0;
      send_done         = 1'b0;
      calm              = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.code_point = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].known) begin
            t = predict_case_traits(directed[i].cp);
            if (t.fam != directed[i].fam || t.up != directed[i].up || t.oc != directed[i].oc)
               report_mismatch("table row", t.oc, directed[i].oc);
         end
         send_request(directed[i].cp);
      end
      for (int n = 0; n < RandomCount; n++) begin
         if (n == RandomCount - 150) calm = 1'b1;
         send_request(random_code_point());
      end
      req_ch.valid <= 1'b0;
      send_done = 1'b1;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      case_traits_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_traits.size() == 0) begin
            report_mismatch("unexpected response", rsp_ch.other_case, 16'h0000);
         end else begin
            want = expected_traits.pop_front();
            if (rsp_ch.script_family !== want.fam)
               report_mismatch("script_family", 16'(rsp_ch.script_family), 16'(want.fam));
            if (rsp_ch.is_upper !== want.up)
               report_mismatch("is_upper", 16'(rsp_ch.is_upper), 16'(want.up));
            if (rsp_ch.other_case !== want.oc)
               report_mismatch("other_case", rsp_ch.other_case, want.oc);
         end
      end
   end

   initial begin
      idle_count = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_count = 0;
         end else begin
            idle_count++;
         end
         if (send_done && expected_traits.size() == 0) begin
            repeat (10) @(posedge clock);
            if (error_count == 0) begin
               $display("unicode_case_traits_core test passed");
            end else begin
               $display("unicode_case_traits_core test failed");
            end
            $finish;
         end else if (idle_count >= StallLimit) begin
            $display("watchdog timeout");
            $display("unicode_case_traits_core test failed");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
hdl/uct_pkg.sv
hdl/uct_if.sv
hdl/unicode_case_traits_core.sv
tb/tb_unicode_case_traits_core.sv
